/* design/wrsi_pkg.sv */
// Shared types and constants for the streaming Wilder RSI block.
// Payload structs, controller/datapath command and status, and fixed widths.
// No dependencies.
package wrsi_pkg;

  localparam int PRICE_BITS         = 32;
  localparam int FRACTION_BITS_DEF  = 16;
  localparam int CALC_BITS          = 64;
  localparam int PERIOD_BITS        = 8;
  localparam int INDEX_BITS         = 9;
  localparam int RSI_BITS           = 15;
  localparam int DATA_BITS          = 32;
  localparam int ADDR_BITS          = 3;
  localparam int PERIOD_RESET       = 14;

  localparam logic [RSI_BITS-1:0] RSI_FULL = 15'd25600;
  localparam logic [RSI_BITS-1:0] RSI_HALF = 15'd12800;

  // Register index, taken from paddr above the byte offset
  localparam logic [ADDR_BITS-3:0] REG_PERIOD = '0;

  typedef struct packed {
    logic [PRICE_BITS-1:0] close_price;
    logic                  series_start;
  } in_word_t;

  typedef struct packed {
    logic [RSI_BITS-1:0] rsi_value;
    logic                rsi_valid;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV_GAIN,
    ST_DIV_LOSS,
    ST_RSI,
    ST_DIV_RSI,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_WARM,
    PH_SEED,
    PH_SMOOTH
  } phase_t;

  typedef enum logic [2:0] {
    DIV_SEED_GAIN,
    DIV_SEED_LOSS,
    DIV_SMOOTH_GAIN,
    DIV_SMOOTH_LOSS,
    DIV_RATIO
  } div_op_t;

  typedef enum logic [1:0] {
    RES_WARM,
    RES_HALF,
    RES_FULL,
    RES_QUOT
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     clear_avg;
    logic     accum;
    logic     div_start;
    div_op_t  div_op;
    logic     wr_gain;
    logic     wr_loss;
    logic     res_wr;
    res_sel_t res_sel;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    phase_t phase;
    logic   gain_zero;
    logic   loss_zero;
    logic   den_zero;
    logic   div_done;
  } dp_status_t;

endpackage

/* design/wrsi_ctrl.sv */
// Sequencer for the Wilder RSI block: walks each word through update and,
// past warm-up, the two average divisions and, if needed, the ratio division. Uses wrsi_pkg.
module wrsi_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  wrsi_pkg::dp_status_t status,
  output wrsi_pkg::ctrl_cmd_t  cmd
);

  wrsi_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wrsi_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ready = (state == wrsi_pkg::ST_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.div_op    = wrsi_pkg::DIV_SEED_GAIN;
    cmd.res_sel   = wrsi_pkg::RES_WARM;
    unique case (state)
      wrsi_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = wrsi_pkg::ST_UPDATE;
        end
      end
      wrsi_pkg::ST_UPDATE: begin
        unique case (status.phase)
          wrsi_pkg::PH_START: begin
            cmd.clear_avg = 1'b1;
            cmd.res_wr    = 1'b1;
            state_next    = wrsi_pkg::ST_EMIT;
          end
          wrsi_pkg::PH_WARM: begin
            cmd.accum  = 1'b1;
            cmd.res_wr = 1'b1;
            state_next = wrsi_pkg::ST_EMIT;
          end
          wrsi_pkg::PH_SEED: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = wrsi_pkg::DIV_SEED_GAIN;
            state_next    = wrsi_pkg::ST_DIV_GAIN;
          end
          wrsi_pkg::PH_SMOOTH: begin
            cmd.div_start = 1'b1;
            cmd.div_op    = wrsi_pkg::DIV_SMOOTH_GAIN;
            state_next    = wrsi_pkg::ST_DIV_GAIN;
          end
          default: begin
            state_next = wrsi_pkg::ST_IDLE;
          end
        endcase
      end
      wrsi_pkg::ST_DIV_GAIN: begin
        // loss division does not depend on the new gain average, so chain it
        if (status.div_done) begin
          cmd.wr_gain   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_op    = (status.phase == wrsi_pkg::PH_SEED) ?
                          wrsi_pkg::DIV_SEED_LOSS : wrsi_pkg::DIV_SMOOTH_LOSS;
          state_next    = wrsi_pkg::ST_DIV_LOSS;
        end
      end
      wrsi_pkg::ST_DIV_LOSS: begin
        if (status.div_done) begin
          cmd.wr_loss = 1'b1;
          state_next  = wrsi_pkg::ST_RSI;
        end
      end
      wrsi_pkg::ST_RSI: begin
        cmd.res_wr = 1'b1;
        priority if (status.loss_zero) begin
          cmd.res_sel = status.gain_zero ? wrsi_pkg::RES_HALF : wrsi_pkg::RES_FULL;
          state_next  = wrsi_pkg::ST_EMIT;
        end else if (status.den_zero) begin
          cmd.res_sel = wrsi_pkg::RES_HALF;
          state_next  = wrsi_pkg::ST_EMIT;
        end else begin
          cmd.res_wr    = 1'b0;
          cmd.div_start = 1'b1;
          cmd.div_op    = wrsi_pkg::DIV_RATIO;
          state_next    = wrsi_pkg::ST_DIV_RSI;
        end
      end
      wrsi_pkg::ST_DIV_RSI: begin
        if (status.div_done) begin
          cmd.res_wr  = 1'b1;
          cmd.res_sel = wrsi_pkg::RES_QUOT;
          state_next  = wrsi_pkg::ST_EMIT;
        end
      end
      wrsi_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = wrsi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wrsi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/wrsi_div.sv */
// Shared restoring divider, one quotient bit per cycle, 64-bit divisor.
// Dividend is scaled by 2^FRACTION_BITS in long mode. Uses wrsi_pkg.
module wrsi_div #(
  parameter int FRACTION_BITS = wrsi_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           long_mode,
  input  logic [wrsi_pkg::CALC_BITS-1:0] dividend,
  input  logic [wrsi_pkg::CALC_BITS-1:0] divisor,
  output logic [wrsi_pkg::CALC_BITS-1:0] quotient,
  output logic                           done
);

  localparam int DW = wrsi_pkg::CALC_BITS + FRACTION_BITS;
  localparam int CW = $clog2(DW + 1);

  logic [wrsi_pkg::CALC_BITS-1:0] rem;
  logic [wrsi_pkg::CALC_BITS-1:0] dvs;
  logic [DW-1:0]                  quo;
  logic [CW-1:0]                  cnt;
  logic                           busy;

  logic [wrsi_pkg::CALC_BITS:0]   trial;
  logic [wrsi_pkg::CALC_BITS:0]   diff;
  logic                           fits;

  always_comb begin
    trial = {rem, quo[DW-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        // short mode runs only over the upper CALC_BITS of the shift register
        cnt  <= long_mode ? CW'(DW) : CW'(wrsi_pkg::CALC_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= {dividend, {FRACTION_BITS{1'b0}}};
    end else if (busy) begin
      rem <= fits ? diff[wrsi_pkg::CALC_BITS-1:0] : trial[wrsi_pkg::CALC_BITS-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign quotient = quo[wrsi_pkg::CALC_BITS-1:0];

endmodule

/* design/wrsi_dp.sv */
// Datapath for the Wilder RSI block: price change, averages, operand
// selection for the shared divider and the result registers. Uses wrsi_pkg, wrsi_div.
module wrsi_dp #(
  parameter int FRACTION_BITS = wrsi_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  wrsi_pkg::ctrl_cmd_t              cmd,
  output wrsi_pkg::dp_status_t             status,
  input  wrsi_pkg::in_word_t               in_data,
  input  logic [wrsi_pkg::PERIOD_BITS-1:0] period,
  output wrsi_pkg::out_word_t              out_data
);

  localparam int CB = wrsi_pkg::CALC_BITS;
  localparam int PB = wrsi_pkg::PRICE_BITS;
  localparam int IB = wrsi_pkg::INDEX_BITS;
  localparam int RB = wrsi_pkg::RSI_BITS;

  logic [PB-1:0]                    previous_close;
  logic [IB-1:0]                    item_index;
  logic [IB-1:0]                    cur_index;
  logic [wrsi_pkg::PERIOD_BITS-1:0] p_r;
  logic [PB-1:0]                    gain_r;
  logic [PB-1:0]                    loss_r;
  logic [CB-1:0]                    average_gain;
  logic [CB-1:0]                    average_loss;
  logic [RB-1:0]                    res_value;
  logic                             res_valid;

  logic [wrsi_pkg::PERIOD_BITS-1:0] p_eff;
  logic [IB-1:0]                    idx;
  logic [IB-1:0]                    idx_inc;
  logic [IB-1:0]                    p_inc;
  logic [IB-1:0]                    p_ext;
  logic                             rising;

  logic [CB-1:0] gain_ext;
  logic [CB-1:0] loss_ext;
  logic [CB-1:0] pm1_ext;
  logic [CB-1:0] den;
  logic [CB-1:0] scaled_gain;

  logic          div_long;
  logic [CB-1:0] div_dividend;
  logic [CB-1:0] div_divisor;
  logic [CB-1:0] div_quotient;
  logic          div_done;

  // Input side
  always_comb begin
    p_eff   = (period == '0) ? wrsi_pkg::PERIOD_BITS'(1) : period;
    idx     = in_data.series_start ? '0 : item_index;
    idx_inc = idx + 1'b1;
    p_inc   = IB'(p_eff) + 1'b1;
    rising  = (in_data.close_price >= previous_close);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_index <= '0;
    end else if (cmd.load) begin
      item_index <= (idx_inc > p_inc) ? p_inc : idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      previous_close <= in_data.close_price;
      cur_index      <= idx;
      p_r            <= p_eff;
      gain_r         <= rising ? (in_data.close_price - previous_close) : '0;
      loss_r         <= rising ? '0 : (previous_close - in_data.close_price);
    end
  end

  // Averages
  always_comb begin
    gain_ext    = CB'(gain_r);
    loss_ext    = CB'(loss_r);
    pm1_ext     = CB'(p_r - 1'b1);
    den         = average_gain + average_loss;
    // 25600 = 2^14 + 2^13 + 2^10
    scaled_gain = (average_gain << 14) + (average_gain << 13) + (average_gain << 10);
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_avg) begin
      average_gain <= '0;
      average_loss <= '0;
    end else if (cmd.accum) begin
      average_gain <= average_gain + gain_ext;
      average_loss <= average_loss + loss_ext;
    end else begin
      if (cmd.wr_gain) begin
        average_gain <= div_quotient;
      end
      if (cmd.wr_loss) begin
        average_loss <= div_quotient;
      end
    end
  end

  // Divider operands
  always_comb begin
    div_long     = 1'b0;
    div_dividend = '0;
    div_divisor  = CB'(p_r);
    unique case (cmd.div_op)
      wrsi_pkg::DIV_SEED_GAIN: begin
        div_long     = 1'b1;
        div_dividend = average_gain + gain_ext;
      end
      wrsi_pkg::DIV_SEED_LOSS: begin
        div_long     = 1'b1;
        div_dividend = average_loss + loss_ext;
      end
      wrsi_pkg::DIV_SMOOTH_GAIN: begin
        div_dividend = CB'(average_gain * pm1_ext) + (gain_ext << FRACTION_BITS);
      end
      wrsi_pkg::DIV_SMOOTH_LOSS: begin
        div_dividend = CB'(average_loss * pm1_ext) + (loss_ext << FRACTION_BITS);
      end
      wrsi_pkg::DIV_RATIO: begin
        div_dividend = scaled_gain;
        div_divisor  = den;
      end
      default: begin
        div_dividend = '0;
      end
    endcase
  end

  wrsi_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .long_mode(div_long),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  // Status
  always_comb begin
    p_ext = IB'(p_r);
    priority if (cur_index == '0) begin
      status.phase = wrsi_pkg::PH_START;
    end else if (cur_index < p_ext) begin
      status.phase = wrsi_pkg::PH_WARM;
    end else if (cur_index == p_ext) begin
      status.phase = wrsi_pkg::PH_SEED;
    end else begin
      status.phase = wrsi_pkg::PH_SMOOTH;
    end
    status.gain_zero = (average_gain == '0);
    status.loss_zero = (average_loss == '0);
    status.den_zero  = (den == '0);
    status.div_done  = div_done;
  end

  // Result and output word
  always_ff @(posedge clk) begin
    if (cmd.res_wr) begin
      unique case (cmd.res_sel)
        wrsi_pkg::RES_WARM: begin
          res_value <= '0;
          res_valid <= 1'b0;
        end
        wrsi_pkg::RES_HALF: begin
          res_value <= wrsi_pkg::RSI_HALF;
          res_valid <= 1'b1;
        end
        wrsi_pkg::RES_FULL: begin
          res_value <= wrsi_pkg::RSI_FULL;
          res_valid <= 1'b1;
        end
        wrsi_pkg::RES_QUOT: begin
          res_value <= div_quotient[RB-1:0];
          res_valid <= 1'b1;
        end
        default: begin
          res_value <= '0;
          res_valid <= 1'b0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_data.rsi_value <= res_value;
      out_data.rsi_valid <= res_valid;
    end
  end

endmodule

/* design/wilder_rsi_streaming.sv */
// Streaming Wilder RSI, one word in flight at a time. Words that close the seed window
// or follow it take the two average divisions and the ratio division, which is
// skipped when a zero average decides the result. The shared one-bit-per-cycle
// divider sets the time per word; output stalls add to it.
// Reset (rst, synchronous): period returns to 14, index to zero, no word pending.
module wilder_rsi_streaming #(
  parameter int FRACTION_BITS = wrsi_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  wrsi_pkg::in_word_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output wrsi_pkg::out_word_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wrsi_pkg::ADDR_BITS-1:0] paddr,
  input  logic [wrsi_pkg::DATA_BITS-1:0] pwdata,
  output logic [wrsi_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);

  logic [wrsi_pkg::PERIOD_BITS-1:0] period;
  logic                             reg_hit;
  wrsi_pkg::ctrl_cmd_t              cmd;
  wrsi_pkg::dp_status_t             status;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[wrsi_pkg::ADDR_BITS-1:2] == wrsi_pkg::REG_PERIOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= wrsi_pkg::PERIOD_BITS'(wrsi_pkg::PERIOD_RESET);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      period <= pwdata[wrsi_pkg::PERIOD_BITS-1:0];
    end
  end

  assign prdata = reg_hit ? wrsi_pkg::DATA_BITS'(period) : '0;

  wrsi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wrsi_dp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .in_data (in_data),
    .period  (period),
    .out_data(out_data)
  );

endmodule

/* dv/tb_wilder_rsi_streaming.sv */
// Self-checking testbench for wilder_rsi_streaming: drives closing prices, predicts each RSI
// word in its own fixed-point model and compares every output word field by field.
// Depends on wrsi_pkg and the wilder_rsi_streaming RTL.
module tb_wilder_rsi_streaming;

  localparam int FB = wrsi_pkg::FRACTION_BITS_DEF;
  localparam int DRAIN_LIMIT = 50000;
  localparam logic [wrsi_pkg::ADDR_BITS-1:0] PERIOD_ADDR = {wrsi_pkg::REG_PERIOD, 2'b00};

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  wrsi_pkg::in_word_t             in_data;
  logic                           out_valid;
  logic                           out_ready = 1'b1;
  wrsi_pkg::out_word_t            out_data;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [wrsi_pkg::ADDR_BITS-1:0] paddr;
  logic [wrsi_pkg::DATA_BITS-1:0] pwdata;
  logic [wrsi_pkg::DATA_BITS-1:0] prdata;
  logic                           pready;

  // Predictor state
  logic [7:0]  pred_period;
  bit   [63:0] pred_prev_close;
  bit   [63:0] pred_index;
  bit   [63:0] pred_avg_gain;
  bit   [63:0] pred_avg_loss;

  wrsi_pkg::out_word_t expected_rsi[$];
  logic [31:0] last_close;
  bit          idle_on;
  int          errors;
  int          words_sent;
  int          results_seen;
  int          valid_seen;
  int          period_writes;

  wilder_rsi_streaming i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  function automatic bit [63:0] seed_mean(bit [63:0] sum, bit [63:0] p);
    bit [63:0] q;
    bit [63:0] r;
    q = sum / p;
    r = sum % p;
    return (q << FB) + ((r << FB) / p);
  endfunction

  // Advance the predictor by one close and return the RSI word it must produce.
  function automatic wrsi_pkg::out_word_t wilder_next(logic [31:0] price, logic start);
    bit [63:0] close;
    bit [63:0] p;
    bit [63:0] i;
    bit [63:0] gain;
    bit [63:0] loss;
    bit [63:0] value;
    bit [63:0] den;
    bit        valid;
    wrsi_pkg::out_word_t word;
    close = {32'b0, price};
    p     = (pred_period == 8'd0) ? 64'd1 : {56'b0, pred_period};
    i     = start ? 64'd0 : pred_index;
    gain  = '0;
    loss  = '0;
    value = '0;
    valid = 1'b0;
    if (i == 0) begin
      pred_avg_gain = '0;
      pred_avg_loss = '0;
    end else begin
      if (close >= pred_prev_close) gain = close - pred_prev_close;
      else loss = pred_prev_close - close;
      if (i < p) begin
        pred_avg_gain += gain;
        pred_avg_loss += loss;
      end else if (i == p) begin
        pred_avg_gain = seed_mean(pred_avg_gain + gain, p);
        pred_avg_loss = seed_mean(pred_avg_loss + loss, p);
        valid = 1'b1;
      end else begin
        pred_avg_gain = (pred_avg_gain * (p - 1) + (gain << FB)) / p;
        pred_avg_loss = (pred_avg_loss * (p - 1) + (loss << FB)) / p;
        valid = 1'b1;
      end
      if (valid) begin
        den = pred_avg_gain + pred_avg_loss;
        if (pred_avg_loss == 0)
          value = (pred_avg_gain == 0) ? 64'(wrsi_pkg::RSI_HALF) : 64'(wrsi_pkg::RSI_FULL);
        else if (den == 0) value = 64'(wrsi_pkg::RSI_HALF);
        else value = (64'd25600 * pred_avg_gain) / den;
      end
    end
    pred_prev_close = close;
    pred_index = (i + 1 > p + 1) ? p + 1 : i + 1;
    word.rsi_value = value[wrsi_pkg::RSI_BITS-1:0];
    word.rsi_valid = valid;
    return word;
  endfunction

  function automatic logic [31:0] pick_close(logic [31:0] last);
    logic [31:0] step;
    step = $urandom_range(0, 2000);
    unique case ($urandom_range(0, 15))
      0: return $urandom;
      1: return '0;
      2: return '1;
      3: return last;
      default: begin
        if ($urandom_range(0, 1)) return (last > 32'hFFFF_FFFF - step) ? last : last + step;
        else return (last < step) ? last : last - step;
      end
    endcase
  endfunction

  // Receiver stalls in random bursts while idling is allowed.
  always begin
    @(negedge clk);
    if (idle_on && !rst && $urandom_range(0, 7) == 0) begin
      out_ready = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    out_ready = 1'b1;
  end

  always @(posedge clk) begin : check_results
    wrsi_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (out_data.rsi_valid) valid_seen++;
      if (expected_rsi.size() == 0) begin
        flag_error($sformatf("RSI word with none expected: value %0d valid %0d",
                             out_data.rsi_value, out_data.rsi_valid));
      end else begin
        want = expected_rsi.pop_front();
        if (out_data.rsi_value !== want.rsi_value || out_data.rsi_valid !== want.rsi_valid)
          flag_error($sformatf("RSI mismatch: expected value %0d valid %0d, got value %0d valid %0d",
                               want.rsi_value, want.rsi_valid,
                               out_data.rsi_value, out_data.rsi_valid));
      end
    end
  end

  task automatic send_close(logic [31:0] price, logic start);
    wrsi_pkg::out_word_t next_word;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      // chain bursts so the gap can end early or late in the block's busy window
      repeat ($urandom_range(1, 20)) repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_data.close_price  = price;
    in_data.series_start = start;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    next_word = wilder_next(price, start);
    expected_rsi.insert(expected_rsi.size(), next_word);
    last_close = price;
    words_sent++;
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_rsi.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (expected_rsi.size() != 0)
      flag_error($sformatf("%0d RSI words never arrived", expected_rsi.size()));
    repeat (2) @(negedge clk);
  endtask

  task automatic apb_access(logic wr, logic [wrsi_pkg::DATA_BITS-1:0] wdata,
                            output logic [wrsi_pkg::DATA_BITS-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = PERIOD_ADDR;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_period(logic [wrsi_pkg::DATA_BITS-1:0] wdata);
    logic [wrsi_pkg::DATA_BITS-1:0] rd;
    wait_drained();
    apb_access(1'b1, wdata, rd);
    apb_access(1'b0, '0, rd);
    if (rd !== {24'b0, wdata[7:0]})
      flag_error($sformatf("period readback: expected %0d, got %0d", wdata[7:0], rd));
    pred_period = wdata[7:0];
    period_writes++;
  endtask

  task automatic run_series(logic [wrsi_pkg::DATA_BITS-1:0] period_word, int count,
                            int restart_odds);
    logic start;
    write_period(period_word);
    for (int n = 0; n < count; n++) begin
      start = (n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(1, restart_odds) == 1);
      send_close(pick_close(last_close), start);
    end
  endtask

  task automatic test_reset_state();
    logic [wrsi_pkg::DATA_BITS-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== wrsi_pkg::DATA_BITS'(wrsi_pkg::PERIOD_RESET))
      flag_error($sformatf("period after reset: expected %0d, got %0d",
                           wrsi_pkg::PERIOD_RESET, rd));
    // first word after reset acts as a series start even without the flag
    send_close(32'hFFFF_FFFF, 1'b0);
    send_close(32'h0000_0000, 1'b0);
  endtask

  task automatic test_directed_extremes();
    // upper data bits are ignored: period 2
    write_period(32'hABCD_EF02);
    send_close(32'd100, 1'b1);
    send_close(32'd100, 1'b0);
    send_close(32'd100, 1'b0);        // flat seed window: both averages zero
    send_close(32'd200, 1'b0);        // no losses yet
    send_close(32'd0, 1'b0);
    send_close(32'hFFFF_FFFF, 1'b0);
    send_close(32'd0, 1'b0);
    // zero period behaves as one
    write_period(32'h0000_0100);
    send_close(32'd5, 1'b1);
    send_close(32'hFFFF_FFFF, 1'b0);
    send_close(32'd0, 1'b0);
    send_close(32'd0, 1'b0);
    write_period(32'd255);
    send_close(32'd7, 1'b1);
    send_close(32'd8, 1'b0);
  endtask

  task automatic test_period_change_mid_series();
    write_period(32'd3);
    send_close(32'd1000, 1'b1);
    send_close(32'd1100, 1'b0);
    send_close(32'd1050, 1'b0);
    send_close(32'd900, 1'b0);
    send_close(32'd900, 1'b0);
    // index now above the new period: straight to smoothing
    write_period(32'd1);
    send_close(32'd950, 1'b0);
    send_close(32'd800, 1'b0);
    // index below the new period: averages keep accumulating
    write_period(32'd6);
    send_close(32'd800, 1'b0);
    send_close(32'd1200, 1'b0);
    send_close(32'd3000, 1'b0);
  endtask

  task automatic test_random_series();
    logic [wrsi_pkg::DATA_BITS-1:0] plist [7];
    plist[0] = 32'd1;
    plist[1] = 32'd2;
    plist[2] = 32'd3;
    plist[3] = 32'd14;
    plist[4] = $urandom & 32'hFFFF_FF00;
    plist[5] = $urandom_range(4, 30);
    plist[6] = $urandom;
    for (int k = 0; k < 7; k++) run_series(plist[k], 70, 40);
    run_series(32'd255, 300, 100000);
  endtask

  task automatic test_pause_until_drained();
    write_period(32'd4);
    for (int n = 0; n < 30; n++) begin
      if (n == 15) wait_drained();
      send_close(pick_close(last_close), n == 0);
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    run_series(32'd5, 120, 50);
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    idle_on    = 1'b1;
    last_close = 32'd50000;
    pred_period     = wrsi_pkg::PERIOD_BITS'(wrsi_pkg::PERIOD_RESET);
    pred_prev_close = '0;
    pred_index      = '0;
    pred_avg_gain   = '0;
    pred_avg_loss   = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_directed_extremes();
    test_period_change_mid_series();
    test_random_series();
    test_pause_until_drained();
    test_steady_stream();

    wait_drained();
    repeat (300) @(negedge clk);
    $display("Run drove %0d price words across %0d period writes (zero, 1 to 255, mid-series).",
             words_sent, period_writes);
    $display("Checked %0d RSI words, %0d of them past warm-up.", results_seen, valid_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d errors in total", errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
